// ===== sv/pgp_pkg.sv =====
// Package for the polar Gaussian pair generator.
// Holds default widths, fixed-point constants and pipeline depths.
// No dependencies.
`default_nettype none

package pgp_pkg;

	// Default field widths.
	localparam int IN_BITS_DEF  = 16;
	localparam int OUT_BITS_DEF = 16;

	// Number of fraction bits in the base-two logarithm.
	localparam int LOG_FRAC = 24;

	// Natural logarithm of two, rounded, in Q0.32.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Width of the normalised mantissa used by the logarithm.
	localparam int NORM_W = 32;

	// Quotient bits of the ratio w^2 / r (Q.32, at most one).
	localparam int DIV_STEPS = 33;

	// Result bits of the integer square root of a 64-bit value.
	localparam int ROOT_STEPS = 32;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== sv/polar_gaussian_pair.sv =====
// Polar-method Gaussian pair generator, top level.
// Each accepted pair yields two samples, the second following the first.
// Throughput: one pair a cycle is taken in while full is low; the result port gives one
// sample a cycle while pop is held and empty is low, and rejected pairs cost nothing there.
// Reset: arst_n clears all control state asynchronously; the queue and pipeline start empty.
`default_nettype none

module polar_gaussian_pair #(
	parameter int IN_BITS  = pgp_pkg::IN_BITS_DEF,
	parameter int OUT_BITS = pgp_pkg::OUT_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	output logic                       full,
	input  wire  signed [IN_BITS-1:0]  u_val,
	input  wire  signed [IN_BITS-1:0]  v_val,
	output logic                       empty,
	input  wire                        pop,
	output logic signed [OUT_BITS-1:0] sample,
	output logic                       last
);

	localparam int RW = 2 * IN_BITS - 1;
	localparam int QW = 3 * RW + 2;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	// Front: accept, square and classify each transaction.
	pgp_front #(
		.IN_BITS (IN_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.u_val   (u_val),
		.v_val   (v_val),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_full  (q_full)
	);

	// Decoupling queue.
	pgp_queue #(
		.DW    (QW),
		.DEPTH (pgp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rdata   (q_rdata),
		.q_empty (q_empty)
	);

	// Back: arithmetic pipeline and output serialisation.
	pgp_back #(
		.IN_BITS  (IN_BITS),
		.OUT_BITS (OUT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.sample  (sample),
		.last    (last)
	);

endmodule

`default_nettype wire

// ===== sv/pgp_front.sv =====
// Front end of the polar Gaussian pair generator: accepts uniform pairs,
// squares them and drops pairs that fall outside the unit disc or on its centre.
// Depends on pgp_pkg (none of its names are needed here beyond widths).
`default_nettype none

module pgp_front #(
	parameter int IN_BITS = pgp_pkg::IN_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire  signed [IN_BITS-1:0]    u_val,
	input  wire  signed [IN_BITS-1:0]    v_val,
	output logic                         q_push,
	output logic [3*(2*IN_BITS-1)+1:0]   q_wdata,
	input  wire                          q_full
);

	localparam int FB = 2 * (IN_BITS - 1);
	localparam int RW = FB + 1;
	localparam logic [RW:0] R_ONE = (RW + 1)'(1) << FB;

	logic                 vld_s1;
	logic [IN_BITS-1:0]   mu_s1;
	logic [IN_BITS-1:0]   mv_s1;
	logic                 un_s1;
	logic                 vn_s1;

	logic                 vld_s2;
	logic [RW-1:0]        u2_s2;
	logic [RW-1:0]        v2_s2;
	logic                 un_s2;
	logic                 vn_s2;

	logic                 accept;
	logic                 adv;
	logic                 reject;
	logic [RW:0]          r_sum;
	logic [IN_BITS-1:0]   mu_in;
	logic [IN_BITS-1:0]   mv_in;
	logic [2*IN_BITS-1:0] pu;
	logic [2*IN_BITS-1:0] pv;

	// Magnitudes of the incoming values; the most negative code maps to 2^(IN_BITS-1).
	assign mu_in = u_val[IN_BITS-1] ? (~u_val + 1'b1) : u_val;
	assign mv_in = v_val[IN_BITS-1] ? (~v_val + 1'b1) : v_val;

	// Radius test on the squared stage; rejected pairs simply vanish.
	assign r_sum  = {1'b0, u2_s2} + {1'b0, v2_s2};
	assign reject = (r_sum == '0) || (r_sum > R_ONE);
	assign q_push = vld_s2 && !reject;
	assign q_wdata = {u2_s2, v2_s2, r_sum[RW-1:0], un_s2, vn_s2};

	// Stage two moves when it is empty, when it holds a reject or when the queue has room.
	assign adv    = !vld_s2 || reject || !q_full;
	assign full   = vld_s1 && !adv;
	assign accept = push && !full;

	// Squares of the magnitudes.
	assign pu = (2 * IN_BITS)'(mu_s1) * (2 * IN_BITS)'(mu_s1);
	assign pv = (2 * IN_BITS)'(mv_s1) * (2 * IN_BITS)'(mv_s1);

	// Stage one and stage two control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!vld_s1 || adv) begin
				vld_s1 <= accept;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			mu_s1 <= mu_in;
			mv_s1 <= mv_in;
			un_s1 <= u_val[IN_BITS-1];
			vn_s1 <= v_val[IN_BITS-1];
		end
		if (adv && vld_s1) begin
			u2_s2 <= pu[RW-1:0];
			v2_s2 <= pv[RW-1:0];
			un_s2 <= un_s1;
			vn_s2 <= vn_s1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pgp_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Register-based storage with a fill count; depends on pgp_pkg for its default depth.
`default_nettype none

module pgp_queue #(
	parameter int DW    = 8,
	parameter int DEPTH = pgp_pkg::QUEUE_DEPTH
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           wr_en,
	input  wire  [DW-1:0] wdata,
	output logic          q_full,
	input  wire           rd_en,
	output logic [DW-1:0] rdata,
	output logic          q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pgp_back.sv =====
// Back end of the polar Gaussian pair generator: logarithm, division,
// scaling, square root and output serialisation, as one stallable pipeline.
// Depends on pgp_pkg for fixed-point constants and stage counts.
`default_nettype none

module pgp_back #(
	parameter int IN_BITS  = pgp_pkg::IN_BITS_DEF,
	parameter int OUT_BITS = pgp_pkg::OUT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_empty,
	input  wire  [3*(2*IN_BITS-1)+1:0]   q_rdata,
	output logic                         q_pop,
	output logic                         empty,
	input  wire                          pop,
	output logic signed [OUT_BITS-1:0]   sample,
	output logic                         last
);

	localparam int FB  = 2 * (IN_BITS - 1);
	localparam int RW  = FB + 1;
	localparam int KW  = $clog2(RW);
	localparam int LF  = pgp_pkg::LOG_FRAC;
	localparam int LW  = KW + LF;
	localparam int PW  = LW + 32;
	localparam int NW  = PW - 31;
	localparam int ND  = pgp_pkg::DIV_STEPS;
	localparam int NS  = pgp_pkg::ROOT_STEPS;
	localparam int XW  = pgp_pkg::NORM_W;
	localparam int OSH = 32 - OUT_BITS;
	localparam logic [OUT_BITS-1:0] HALF = OUT_BITS'(1) << (OUT_BITS - 1);

	// Pipeline advance: the output register is free or is being emptied.
	logic adv;

	// Stage one: transaction from the queue with its exponent.
	logic            vld_s1;
	logic [RW-1:0]   r_s1;
	logic [RW-1:0]   u2_s1;
	logic [RW-1:0]   v2_s1;
	logic            un_s1;
	logic            vn_s1;
	logic [KW-1:0]   k_s1;
	logic [KW-1:0]   k_in;
	logic [RW-1:0]   r_in;

	// Normalisation of stage one.
	logic [6:0]      kx;
	logic [6:0]      sh;
	logic [63:0]     rx;
	logic [XW-1:0]   x_n;
	logic [31:0]     rs_n;
	logic [31:0]     wu_n;
	logic [31:0]     wv_n;

	// Division and logarithm stages.
	logic            vld_s   [0:ND];
	logic            un_s    [0:ND];
	logic            vn_s    [0:ND];
	logic [31:0]     rs_s    [0:ND-1];
	logic [31:0]     rmu_s   [0:ND];
	logic [31:0]     rmv_s   [0:ND];
	logic [32:0]     qu_s    [0:ND];
	logic [32:0]     qv_s    [0:ND];
	logic [XW-1:0]   x_s     [0:LF-1];
	logic [LF-1:0]   fr_s    [0:LF];
	logic [KW-1:0]   k_s     [0:LF];
	logic [NW-1:0]   n_s     [LF+1:ND];

	// Scaling stages.
	logic            vld_s3;
	logic            un_s3;
	logic            vn_s3;
	logic [NW-1:0]   n_s3;
	logic            hu_s3;
	logic            hv_s3;
	logic [NW+31:0]  pu_s3;
	logic [NW+31:0]  pv_s3;

	// Square-root stages.
	logic            rvld_s  [0:NS];
	logic            run_s   [0:NS];
	logic            rvn_s   [0:NS];
	logic [63:0]     sru_s   [0:NS-1];
	logic [63:0]     srv_s   [0:NS-1];
	logic [63:0]     rtu_s   [0:NS];
	logic [63:0]     rtv_s   [0:NS];

	// Output register holding both samples of one pair.
	logic                 out_vld_q;
	logic                 ph_q;
	logic [OUT_BITS-1:0]  su_q;
	logic [OUT_BITS-1:0]  sv_q;
	logic [OUT_BITS-1:0]  mu_f;
	logic [OUT_BITS-1:0]  mv_f;

	function automatic logic [OUT_BITS-1:0] sat_sign(input logic [OUT_BITS-1:0] m,
							 input logic neg);
		logic [OUT_BITS-1:0] mm;
		begin
			if (neg) begin
				mm = (m > HALF) ? HALF : m;
				sat_sign = ~mm + 1'b1;
			end else begin
				sat_sign = (m > HALF - 1'b1) ? HALF - 1'b1 : m;
			end
		end
	endfunction

	assign adv   = !out_vld_q || (pop && ph_q);
	assign q_pop = adv && !q_empty;

	// Exponent of the radius: position of its leading one.
	assign r_in = q_rdata[RW+1:2];
	always_comb begin
		k_in = '0;
		for (int i = 0; i < RW; i++) begin
			if (r_in[i]) begin
				k_in = KW'(i);
			end
		end
	end

	// Radius mantissa into [2^31, 2^32); radius and squares shift alike.
	assign kx   = 7'(k_s1);
	assign sh   = (kx >= 7'd31) ? kx - 7'd31 : 7'd0;
	assign rx   = 64'(r_s1);
	assign x_n  = (kx >= 7'd31) ? XW'(rx >> sh) : XW'(rx << (7'd31 - kx));
	assign rs_n = 32'(rx >> sh);
	assign wu_n = 32'(64'(u2_s1) >> sh);
	assign wv_n = 32'(64'(v2_s1) >> sh);

	// Control of the first two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s[0]  <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !q_empty;
			vld_s[0]  <= vld_s1;
		end
	end

	// Payload of the first two stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1     <= r_in;
			u2_s1    <= q_rdata[3*RW+1:2*RW+2];
			v2_s1    <= q_rdata[2*RW+1:RW+2];
			un_s1    <= q_rdata[1];
			vn_s1    <= q_rdata[0];
			k_s1     <= k_in;
			un_s[0]  <= un_s1;
			vn_s[0]  <= vn_s1;
			rs_s[0]  <= rs_n;
			rmu_s[0] <= wu_n;
			rmv_s[0] <= wv_n;
			qu_s[0]  <= '0;
			qv_s[0]  <= '0;
			x_s[0]   <= x_n;
			fr_s[0]  <= '0;
			k_s[0]   <= k_s1;
		end
	end

	// Restoring division one quotient bit a stage, logarithm alongside.
	for (genvar i = 1; i <= ND; i++) begin : g_div
		logic [32:0] tu;
		logic [32:0] tv;
		logic        gu;
		logic        gv;

		assign tu = (i == 1) ? {1'b0, rmu_s[i-1]} : {rmu_s[i-1], 1'b0};
		assign tv = (i == 1) ? {1'b0, rmv_s[i-1]} : {rmv_s[i-1], 1'b0};
		assign gu = tu >= {1'b0, rs_s[i-1]};
		assign gv = tv >= {1'b0, rs_s[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				un_s[i]  <= un_s[i-1];
				vn_s[i]  <= vn_s[i-1];
				rmu_s[i] <= gu ? 32'(tu - {1'b0, rs_s[i-1]}) : tu[31:0];
				rmv_s[i] <= gv ? 32'(tv - {1'b0, rs_s[i-1]}) : tv[31:0];
				qu_s[i]  <= qu_s[i-1] | (33'(gu) << (ND - i));
				qv_s[i]  <= qv_s[i-1] | (33'(gv) << (ND - i));
			end
		end

		if (i < ND) begin : g_rs
			always_ff @(posedge clk) begin
				if (adv) begin
					rs_s[i] <= rs_s[i-1];
				end
			end
		end

		if (i <= LF) begin : g_log
			logic [63:0] sq;
			logic [32:0] t;

			// One fraction bit of log2 by squaring the mantissa.
			assign sq = 64'(x_s[i-1]) * 64'(x_s[i-1]);
			assign t  = sq[63:31];

			always_ff @(posedge clk) begin
				if (adv) begin
					fr_s[i] <= {fr_s[i-1][LF-2:0], t[32]};
					k_s[i]  <= k_s[i-1];
				end
			end

			if (i < LF) begin : g_x
				always_ff @(posedge clk) begin
					if (adv) begin
						x_s[i] <= t[32] ? t[32:1] : t[31:0];
					end
				end
			end
		end else if (i == LF + 1) begin : g_ln
			logic [LW-1:0] l2;
			logic [PW-1:0] prod;

			// -2 ln r from -log2 r.
			assign l2   = (LW'(FB) << LF) - {k_s[LF], fr_s[LF]};
			assign prod = PW'(l2) * PW'(pgp_pkg::LN2_Q32);

			always_ff @(posedge clk) begin
				if (adv) begin
					n_s[i] <= prod[PW-1:31];
				end
			end
		end else begin : g_n
			always_ff @(posedge clk) begin
				if (adv) begin
					n_s[i] <= n_s[i-1];
				end
			end
		end
	end

	// Square of the sample: ratio times -2 ln r, low product first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			rvld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s3    <= vld_s[ND];
			rvld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			un_s3    <= un_s[ND];
			vn_s3    <= vn_s[ND];
			n_s3     <= n_s[ND];
			hu_s3    <= qu_s[ND][32];
			hv_s3    <= qv_s[ND][32];
			pu_s3    <= (NW + 32)'(qu_s[ND][31:0]) * (NW + 32)'(n_s[ND]);
			pv_s3    <= (NW + 32)'(qv_s[ND][31:0]) * (NW + 32)'(n_s[ND]);
			run_s[0] <= un_s3;
			rvn_s[0] <= vn_s3;
			sru_s[0] <= 64'(pu_s3) + (hu_s3 ? (64'(n_s3) << 32) : 64'd0);
			srv_s[0] <= 64'(pv_s3) + (hv_s3 ? (64'(n_s3) << 32) : 64'd0);
			rtu_s[0] <= '0;
			rtv_s[0] <= '0;
		end
	end

	// Integer square root, one result bit a stage.
	for (genvar j = 1; j <= NS; j++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (j - 1));
		logic [63:0] su;
		logic [63:0] sv;
		logic        gu;
		logic        gv;

		assign su = rtu_s[j-1] + BIT;
		assign sv = rtv_s[j-1] + BIT;
		assign gu = sru_s[j-1] >= su;
		assign gv = srv_s[j-1] >= sv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rvld_s[j] <= 1'b0;
			end else if (adv) begin
				rvld_s[j] <= rvld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				run_s[j] <= run_s[j-1];
				rvn_s[j] <= rvn_s[j-1];
				rtu_s[j] <= gu ? (rtu_s[j-1] >> 1) + BIT : rtu_s[j-1] >> 1;
				rtv_s[j] <= gv ? (rtv_s[j-1] >> 1) + BIT : rtv_s[j-1] >> 1;
			end
		end

		if (j < NS) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					sru_s[j] <= gu ? sru_s[j-1] - su : sru_s[j-1];
					srv_s[j] <= gv ? srv_s[j-1] - sv : srv_s[j-1];
				end
			end
		end
	end

	// Drop to the output precision.
	assign mu_f = OUT_BITS'(rtu_s[NS] >> OSH);
	assign mv_f = OUT_BITS'(rtv_s[NS] >> OSH);

	// Output register: the u sample goes first, then the v sample with last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			ph_q      <= 1'b0;
		end else if (adv) begin
			out_vld_q <= rvld_s[NS];
			ph_q      <= 1'b0;
		end else if (pop && out_vld_q) begin
			ph_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			su_q <= sat_sign(mu_f, run_s[NS]);
			sv_q <= sat_sign(mv_f, rvn_s[NS]);
		end
	end

	assign empty  = !out_vld_q;
	assign sample = ph_q ? sv_q : su_q;
	assign last   = ph_q;

endmodule

`default_nettype wire
